[hw/rtl/rat_pkg.sv]
package rat_pkg;

   // table geometry and field widths
   localparam int REGIONS    = 16;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 48;
   localparam int PAGES_W    = 36;
   localparam int IDX_W      = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int CNT_W      = $clog2(REGIONS + 1);
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = PAGES_W + PAGE_SHIFT;
   localparam int CMP_W      = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_V2P    = 2'd2,
      MODE_P2V    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

   // address lies in [base, base + pages pages), no end sum formed
   function automatic logic in_range(input logic [ADDR_W-1:0]  base,
                                     input logic [PAGES_W-1:0] pages,
                                     input logic [ADDR_W-1:0]  addr);
      logic [ADDR_W-1:0] diff;
      logic [LEN_W-1:0]  len;
      diff = addr - base;
      len  = LEN_W'(pages) << PAGE_SHIFT;
      return (addr >= base) && (CMP_W'(diff) < CMP_W'(len));
   endfunction

endpackage

[hw/rtl/rat_req_if.sv]
interface rat_req_if
   import rat_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [ADDR_W-1:0]  virt_addr;
   logic [ADDR_W-1:0]  phys_addr;
   logic [PAGES_W-1:0] page_count;

   modport source (output valid, output mode, output virt_addr, output phys_addr,
                   output page_count, input ready);
   modport sink   (input valid, input mode, input virt_addr, input phys_addr,
                   input page_count, output ready);
endinterface

[hw/rtl/rat_rsp_if.sv]
interface rat_rsp_if
   import rat_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_addr;
   logic [CNT_W-1:0]    regions_used;

   modport source (output valid, output status, output result_addr,
                   output regions_used, input ready);
   modport sink   (input valid, input status, input result_addr,
                   input regions_used, output ready);
endinterface

[hw/rtl/rat_ctrl.sv]
module rat_ctrl
   import rat_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      commit;
   logic      load;

   // commit waits for room in the output register
   assign commit    = (state_ff == ST_COMMIT) && stat.out_free;
   // no item is taken while reset is held
   assign req_ready = !reset && ((state_ff == ST_IDLE) || commit);
   assign load      = req_valid && req_ready;

   assign cmd.load   = load;
   assign cmd.search = (state_ff == ST_SEARCH);
   assign cmd.commit = commit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) state_in = load ? ST_SEARCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/rat_datapath.sv]
module rat_datapath
   import rat_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rat_req_if.sink   req,
   rat_rsp_if.source rsp,
   input  cmd_type  cmd,
   output stat_type stat
);

   // item registers
   mode_type           mode_ff;
   logic [ADDR_W-1:0]  va_ff;
   logic [ADDR_W-1:0]  pa_ff;
   logic [PAGES_W-1:0] pages_ff;

   // region table, packed at the front in insertion order
   logic [ADDR_W-1:0]  virt_ff  [REGIONS];
   logic [ADDR_W-1:0]  phys_ff  [REGIONS];
   logic [PAGES_W-1:0] len_ff   [REGIONS];
   logic [CNT_W-1:0]   count_ff, count_in;

   // search result
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [REGIONS-1:0] match;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [CNT_W-1:0]    rsp_used_ff;

   status_type        status_in;
   logic [ADDR_W-1:0] addr_in;
   logic              add_we;
   logic              rem_we;
   logic [ADDR_W-1:0] sel_virt;
   logic [ADDR_W-1:0] sel_phys;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req.mode);
         va_ff    <= req.virt_addr;
         pa_ff    <= req.phys_addr;
         pages_ff <= req.page_count;
      end
   end

   // per-cell range compare on the key chosen by mode
   always_comb begin
      for (int i = 0; i < REGIONS; i++) begin
         if (mode_ff == MODE_P2V) begin
            match[i] = (CNT_W'(i) < count_ff) && in_range(phys_ff[i], len_ff[i], pa_ff);
         end else begin
            match[i] = (CNT_W'(i) < count_ff) && in_range(virt_ff[i], len_ff[i], va_ff);
         end
      end
   end

   // first match wins
   always_comb begin
      hit_in = 1'b0;
      idx_in = '0;
      for (int i = REGIONS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_in = 1'b1;
            idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
   end

   assign sel_virt = virt_ff[idx_ff];
   assign sel_phys = phys_ff[idx_ff];

   // operation outcome
   always_comb begin
      status_in = STATUS_DONE;
      addr_in   = '0;
      count_in  = count_ff;
      add_we    = 1'b0;
      rem_we    = 1'b0;
      case (mode_ff)
         MODE_ADD: begin
            if (count_ff >= CNT_W'(REGIONS)) begin
               status_in = STATUS_FULL;
            end else begin
               add_we   = cmd.commit;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (!hit_ff) begin
               status_in = STATUS_MISS;
            end else begin
               rem_we   = cmd.commit;
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_V2P: begin
            if (!hit_ff) begin
               status_in = STATUS_MISS;
            end else begin
               addr_in = sel_phys + (va_ff - sel_virt);
            end
         end
         default: begin
            if (!hit_ff) begin
               status_in = STATUS_MISS;
            end else begin
               addr_in = sel_virt + (pa_ff - sel_phys);
            end
         end
      endcase
   end

   // table cells: append at the tail, or shift down over a removed entry
   for (genvar g = 0; g < REGIONS; g++) begin : g_cell
      always_ff @(posedge clock) begin
         if (add_we && (count_ff[IDX_W-1:0] == IDX_W'(g))) begin
            virt_ff[g] <= va_ff;
            phys_ff[g] <= pa_ff;
            len_ff[g]  <= pages_ff;
         end else if (rem_we && (IDX_W'(g) >= idx_ff)) begin
            if (g < REGIONS - 1) begin
               virt_ff[g] <= virt_ff[(g + 1) % REGIONS];
               phys_ff[g] <= phys_ff[(g + 1) % REGIONS];
               len_ff[g]  <= len_ff[(g + 1) % REGIONS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_addr_ff   <= addr_in;
         rsp_used_ff   <= count_in;
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_addr  = rsp_addr_ff;
   assign rsp.regions_used = rsp_used_ff;

endmodule

[hw/rtl/region_address_translation_table.sv]
// Region address translation table.
// An ordered table of up to 16 mappings (virtual base, physical base, pages of
// 4 KiB). Each request item on req_if carries a mode: add appends at the tail,
// remove deletes the first region holding virt_addr and closes the gap, and
// the two lookups translate virtual to physical or back. Every request gives
// exactly one response item on rsp_if with a status (done, miss, full), the
// translated address (zero unless a lookup hits) and the regions now held.
// An accepted item is compared against all cells in the search state, and its
// response is registered in the commit state. A new item is taken in the same
// cycle the previous one commits, so the next item is searched while the
// previous one is still finishing.
// A stalled receiver holds the response in the output register; the next
// item is still taken and searched, then waits to commit until the output
// register is free.
// Reset (synchronous, active high) empties the table and drops any pending
// response; stored bases are not cleared, entries past the fill count are
// ignored.
module region_address_translation_table
   import rat_pkg::*;
(
   input logic clock,
   input logic reset,
   rat_req_if.sink   req_if,
   rat_rsp_if.source rsp_if
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_if.ready = req_ready;

   rat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rat_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

[sim/tb.sv]
module tb;
   import rat_pkg::*;

   typedef struct packed {
      mode_type           mode;
      logic [ADDR_W-1:0]  virt_addr;
      logic [ADDR_W-1:0]  phys_addr;
      logic [PAGES_W-1:0] page_count;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  result_addr;
      logic [CNT_W-1:0]   regions_used;
   } rsp_item_type;

   localparam int RANDOM_ITEMS = 650;
   localparam int CALM_TAIL    = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   // Mirror of the translation table plus the responses it still owes
   class region_table_model;
      logic [ADDR_W-1:0]  virt_base [REGIONS];
      logic [ADDR_W-1:0]  phys_base [REGIONS];
      logic [PAGES_W-1:0] pages     [REGIONS];
      int                 used;
      int                 mismatches;
      rsp_item_type       pending [$];

      function new();
         used       = 0;
         mismatches = 0;
      endfunction

      // containment without forming base + length, so no wrap at the top
      function bit covers(logic [ADDR_W-1:0] base, logic [PAGES_W-1:0] pg,
                          logic [ADDR_W-1:0] addr);
         logic [ADDR_W-1:0] span;
         span = ADDR_W'(pg) << PAGE_SHIFT;
         return (addr >= base) && ((addr - base) < span);
      endfunction

      // first region in insertion order holding addr, -1 on a miss
      function int first_hit(bit by_phys, logic [ADDR_W-1:0] addr);
         for (int i = 0; i < used; i++) begin
            if (covers(by_phys ? phys_base[i] : virt_base[i], pages[i], addr))
               return i;
         end
         return -1;
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         int           k;
         e.status      = STATUS_DONE;
         e.result_addr = '0;
         case (r.mode)
            MODE_ADD: begin
               if (used >= REGIONS) begin
                  e.status = STATUS_FULL;
               end else begin
                  virt_base[used] = r.virt_addr;
                  phys_base[used] = r.phys_addr;
                  pages[used]     = r.page_count;
                  used++;
               end
            end
            MODE_REMOVE: begin
               k = first_hit(1'b0, r.virt_addr);
               if (k < 0) begin
                  e.status = STATUS_MISS;
               end else begin
                  // close the gap, keeping order
                  for (int i = k; i + 1 < used; i++) begin
                     virt_base[i] = virt_base[i+1];
                     phys_base[i] = phys_base[i+1];
                     pages[i]     = pages[i+1];
                  end
                  used--;
               end
            end
            MODE_V2P: begin
               k = first_hit(1'b0, r.virt_addr);
               if (k < 0) e.status = STATUS_MISS;
               else e.result_addr = phys_base[k] + (r.virt_addr - virt_base[k]);
            end
            default: begin
               k = first_hit(1'b1, r.phys_addr);
               if (k < 0) e.status = STATUS_MISS;
               else e.result_addr = virt_base[k] + (r.phys_addr - phys_base[k]);
            end
         endcase
         e.regions_used = CNT_W'(used);
         pending = {pending, e};
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing pending: status %0d addr %h used %0d",
                        $time, got.status, got.result_addr, got.regions_used);
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status || got.result_addr !== e.result_addr ||
             got.regions_used !== e.regions_used) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch (status addr used): exp %0d %h %0d got %0d %h %0d",
                        $time, e.status, e.result_addr, e.regions_used,
                        got.status, got.result_addr, got.regions_used);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_odds;   // 0: no idling, else one chance in idle_odds per slot
   int   quiet_cycles;

   rat_req_if req_bus ();
   rat_rsp_if rsp_bus ();

   region_table_model model = new();

   region_address_translation_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   // clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function req_item_type make_req(mode_type m, logic [ADDR_W-1:0] va,
                                   logic [ADDR_W-1:0] pa, logic [PAGES_W-1:0] pg);
      req_item_type r;
      r.mode       = m;
      r.virt_addr  = va;
      r.phys_addr  = pa;
      r.page_count = pg;
      return r;
   endfunction

   // mostly hits on live regions, with edge offsets; some plain noise
   function req_item_type pick_request(int add_weight);
      req_item_type      r;
      int                roll;
      int                k;
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] off;
      r = make_req(MODE_ADD, rand_addr(), rand_addr(), PAGES_W'({$urandom(), $urandom()}));
      roll = $urandom_range(0, 99);
      if (roll < add_weight || (model.used == 0 && roll < 60)) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) r.page_count = PAGES_W'($urandom_range(1, 16));
         else if (roll == 7) r.page_count = '0;
         // overlap an existing region to exercise first-match order
         if (model.used > 0 && $urandom_range(0, 9) < 3) begin
            k = $urandom_range(0, model.used - 1);
            r.virt_addr = model.virt_base[k] + (ADDR_W'($urandom_range(0, 3)) << PAGE_SHIFT);
            r.phys_addr = model.phys_base[k] + (ADDR_W'($urandom_range(0, 3)) << PAGE_SHIFT);
         end
         return r;
      end
      case ($urandom_range(0, 2))
         0:       r.mode = MODE_REMOVE;
         1:       r.mode = MODE_V2P;
         default: r.mode = MODE_P2V;
      endcase
      if (model.used > 0 && $urandom_range(0, 9) < 8) begin
         k    = $urandom_range(0, model.used - 1);
         span = ADDR_W'(model.pages[k]) << PAGE_SHIFT;
         case ($urandom_range(0, 3))
            0:       off = '0;
            1:       off = (span == 0) ? '0 : span - 1;
            2:       off = span;
            default: off = (span == 0) ? '0 : rand_addr() % span;
         endcase
         if (r.mode == MODE_P2V) r.phys_addr = model.phys_base[k] + off;
         else r.virt_addr = model.virt_base[k] + off;
      end
      return r;
   endfunction

   // one request item: optional idle burst, then hold valid until taken
   task send_request(input req_item_type r);
      int n;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= r.mode;
      req_bus.virt_addr  <= r.virt_addr;
      req_bus.phys_addr  <= r.phys_addr;
      req_bus.page_count <= r.page_count;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      model.note_request(r);
   endtask

   // response side back-pressure in bursts
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         model.check_response({status_type'(rsp_bus.status), rsp_bus.result_addr,
                               rsp_bus.regions_used});
   end

   // watchdog on cycles without any item moving
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int add_weight;
      reset              = 1'b1;
      idle_odds          = 4;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_ADD;
      req_bus.virt_addr  = '0;
      req_bus.phys_addr  = '0;
      req_bus.page_count = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lookups and remove on an empty table
      send_request(make_req(MODE_V2P, '0, '0, '0));
      send_request(make_req(MODE_REMOVE, '1, '1, '1));
      // physical range at the top, zero-page region, virtual range at the
      // top, and a huge region overlapping the first
      send_request(make_req(MODE_ADD, 48'h0000_0000_1000, 48'hFFFF_FFFF_F000, 36'd1));
      send_request(make_req(MODE_ADD, 48'h0000_0000_5000, 48'h0000_0000_9000, 36'd0));
      send_request(make_req(MODE_ADD, 48'hFFFF_FFFF_F000, 48'h0, 36'd1));
      send_request(make_req(MODE_ADD, 48'h0000_0000_1800, 48'h1234_5678_9000, '1));
      send_request(make_req(MODE_V2P, 48'h0000_0000_1FFF, '0, '0));
      send_request(make_req(MODE_V2P, 48'h0000_0000_2000, '0, '0));
      send_request(make_req(MODE_P2V, '0, 48'h0000_0000_9000, '0));
      send_request(make_req(MODE_P2V, '0, 48'hFFFF_FFFF_FFFF, '0));
      send_request(make_req(MODE_V2P, 48'hFFFF_FFFF_FFFF, '0, '0));
      send_request(make_req(MODE_REMOVE, 48'h0000_0000_1000, '0, '0));
      // fill the table, then one add too many
      for (int i = 0; i < REGIONS - 3; i++)
         send_request(make_req(MODE_ADD, ADDR_W'(i + 1) << 32, ADDR_W'(i + 1) << 24,
                               PAGES_W'(i + 1)));
      send_request(make_req(MODE_ADD, rand_addr(), rand_addr(), 36'd4));

      // random phases: fill-heavy, balanced or drain-heavy, varying idling
      add_weight = 30;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       add_weight = 15;
               1:       add_weight = 35;
               default: add_weight = 60;
            endcase
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 3;
               default: idle_odds = 8;
            endcase
         end
         if (n >= RANDOM_ITEMS - CALM_TAIL) idle_odds = 0;
         send_request(pick_request(add_weight));
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (model.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (model.mismatches == 0 && model.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
